FILE: hdl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// Connection tracking table package
// Types, constants and codes shared by the connection tracking table core.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int PROBE_DEPTH   = 8;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int PRB_W         = $clog2(PROBE_DEPTH + 1);

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_RST = 8'h04;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] OP_OUT   = 2'd0;
    localparam logic [1:0] OP_IN    = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLEAN = 2'd3;

    localparam logic [1:0] ST_SYN_SENT    = 2'd0;
    localparam logic [1:0] ST_ESTABLISHED = 2'd1;
    localparam logic [1:0] ST_FIN_WAIT    = 2'd2;

    localparam logic [3:0] ACT_NONE      = 4'd0;
    localparam logic [3:0] ACT_CREATED   = 4'd1;
    localparam logic [3:0] ACT_REFRESHED = 4'd2;
    localparam logic [3:0] ACT_TO_FIN    = 4'd3;
    localparam logic [3:0] ACT_TO_EST    = 4'd4;
    localparam logic [3:0] ACT_RESET     = 4'd5;
    localparam logic [3:0] ACT_FULL      = 4'd6;
    localparam logic [3:0] ACT_NO_MATCH  = 4'd7;
    localparam logic [3:0] ACT_REFUSED   = 4'd8;

    localparam logic [1:0] REG_TO_EST = 2'd0;
    localparam logic [1:0] REG_TO_FIN = 2'd1;
    localparam logic [1:0] REG_TO_SYN = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic        ipv4_valid;
        logic        l4_present;
        logic [7:0]  protocol;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
    } ctt_in_t;

    typedef struct packed {
        logic        allow;
        logic [3:0]  action;
        logic [9:0]  slot;
    } ctt_out_t;

    typedef struct packed {
        logic        active;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [31:0] local_ip;
        logic [15:0] local_port;
        logic        is_tcp;
        logic [1:0]  conn_state;
        logic [31:0] seen_tick;
    } ctt_entry_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HMUL,
        S_READ,
        S_WAIT,
        S_CHECK,
        S_WRITE,
        S_DONE,
        S_CLEAN_RD,
        S_CLEAN_WT,
        S_CLEAN_CK
    } ctt_state_t;

endpackage

FILE: hdl/connection_tracking_table_core.sv
// ----------------------------------------------------------------------------
// Connection tracking table core
// Stateful firewall connection tracker with a hashed, linearly probed table.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with a request beat on req while busy is low. The block goes
//   busy, works the request, and presents one result beat on rsp for exactly
//   one cycle with done high. The receiver cannot stall; results must be taken
//   when done is high.
//   Outbound/inbound packets: 7 hash rounds through one shared multiplier,
//   each round a HASH state then an HMUL state, then up to PROBE_DEPTH table
//   probes through the entry memory (READ, WAIT, CHECK each), plus a write
//   when a new entry is created, then the result (DONE) and a return to IDLE.
//   Unhandled or refused packets and ticks go straight to the result. Cleanup
//   walks every entry (CLEAN_RD, CLEAN_WT, CLEAN_CK) before its result.
//   Configuration: cfg_we, cfg_index, cfg_data write a timeout register;
//   the user must write only while idle, which the block does not enforce.
//   Reset clears the tick clock, timeouts to defaults and the sequencer, then a
//   clearing pass (INIT) marks every entry inactive; busy stays high during
//   that pass.
// ----------------------------------------------------------------------------
module connection_tracking_table_core
    import ctt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  ctt_in_t     req,
    output logic        busy,
    output logic        done,
    output ctt_out_t    rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ctt_state_t state_reg, state_next;

    logic [31:0] to_est_reg, to_fin_reg, to_syn_reg;
    logic [31:0] tick_reg, tick_next;

    ctt_entry_t mem [TABLE_ENTRIES];
    ctt_entry_t rd_reg;

    ctt_in_t     req_reg, req_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] mix_reg, mix_next;
    logic [2:0]  step_reg, step_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [PRB_W-1:0] prb_reg, prb_next;
    logic       have_free_reg, have_free_next;
    logic [IDX_W-1:0] free_reg, free_next;
    ctt_out_t   rsp_reg, rsp_next;

    logic       we;
    logic [IDX_W-1:0] waddr;
    ctt_entry_t wdata;

    logic        is_out;
    logic        is_tcp;
    logic [31:0] rem_ip;
    logic [15:0] rem_port;
    logic [7:0]  hbyte;
    logic [31:0] age;
    logic [31:0] lim;
    logic        live;
    logic        match;
    logic [31:0] prod;

    assign is_out   = (req_reg.operation == OP_OUT);
    assign is_tcp   = (req_reg.protocol == PROTO_TCP);
    assign rem_ip   = is_out ? req_reg.dst_ip : req_reg.src_ip;
    assign rem_port = is_out ? req_reg.dst_port : req_reg.src_port;

    always_comb
    begin
        case (step_reg)
            3'd0:    hbyte = rem_ip[31:24];
            3'd1:    hbyte = rem_ip[23:16];
            3'd2:    hbyte = rem_ip[15:8];
            3'd3:    hbyte = rem_ip[7:0];
            3'd4:    hbyte = rem_port[15:8];
            3'd5:    hbyte = rem_port[7:0];
            default: hbyte = req_reg.protocol;
        endcase
    end

    assign prod = mix_reg * FNV_PRIME;

    assign age = tick_reg - rd_reg.seen_tick;
    always_comb
    begin
        case (rd_reg.conn_state)
            ST_ESTABLISHED: lim = to_est_reg;
            ST_FIN_WAIT:    lim = to_fin_reg;
            default:        lim = to_syn_reg;
        endcase
    end
    assign live  = rd_reg.active && !(age > lim);
    assign match = (rd_reg.peer_ip == rem_ip) && (rd_reg.peer_port == rem_port)
                && (rd_reg.is_tcp == is_tcp)
                && (!is_out || ((rd_reg.local_ip == req_reg.src_ip)
                                && (rd_reg.local_port == req_reg.src_port)));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        hash_next      = hash_reg;
        mix_next       = mix_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        prb_next       = prb_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        rsp_next       = rsp_reg;
        tick_next      = tick_reg;
        we             = 1'b0;
        waddr          = idx_reg;
        wdata          = rd_reg;

        case (state_reg)
            S_INIT:
            begin
                we       = 1'b1;
                wdata    = '0;
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next       = req;
                    rsp_next       = '0;
                    hash_next      = FNV_BASIS;
                    step_next      = '0;
                    prb_next       = '0;
                    have_free_next = 1'b0;
                    free_next      = '0;
                    idx_next       = '0;
                    state_next     = S_DONE;
                    case (req.operation)
                        OP_OUT:
                        begin
                            if (req.ipv4_valid && req.l4_present
                                && (req.protocol == PROTO_TCP || req.protocol == PROTO_UDP))
                                state_next = S_HASH;
                        end
                        OP_IN:
                        begin
                            if (req.ipv4_valid && req.protocol == PROTO_ICMP)
                                rsp_next.allow = 1'b1;
                            else if (!req.ipv4_valid || !req.l4_present
                                     || !(req.protocol == PROTO_TCP
                                          || req.protocol == PROTO_UDP))
                                rsp_next.action = ACT_REFUSED;
                            else
                                state_next = S_HASH;
                        end
                        OP_TICK:
                            tick_next = tick_reg + 32'd1;
                        default:
                            state_next = S_CLEAN_RD;
                    endcase
                end
            end
            S_HASH:
            begin
                mix_next   = hash_reg ^ {24'd0, hbyte};
                state_next = S_HMUL;
            end
            S_HMUL:
            begin
                hash_next = prod;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6)
                begin
                    idx_next   = prod[IDX_W-1:0];
                    state_next = S_READ;
                end
                else
                    state_next = S_HASH;
            end
            S_READ:
                state_next = S_WAIT;
            S_WAIT:
                state_next = S_CHECK;
            S_CHECK:
            begin
                state_next = S_READ;
                if (!live)
                begin
                    if (!have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = idx_reg;
                    end
                end
                else if (match)
                begin
                    rsp_next.slot = 10'(idx_reg);
                    state_next    = S_DONE;
                    if (is_out)
                    begin
                        if (is_tcp && (req_reg.tcp_flags & FLAG_RST) != 8'd0)
                        begin
                            we              = 1'b1;
                            wdata.active    = 1'b0;
                            rsp_next.action = ACT_RESET;
                        end
                        else if (is_tcp && (req_reg.tcp_flags & FLAG_FIN) != 8'd0)
                        begin
                            we               = 1'b1;
                            wdata.conn_state = ST_FIN_WAIT;
                            wdata.seen_tick  = tick_reg;
                            rsp_next.action  = ACT_TO_FIN;
                        end
                        else
                        begin
                            we              = 1'b1;
                            wdata.seen_tick = tick_reg;
                            rsp_next.action = ACT_REFRESHED;
                        end
                    end
                    else
                    begin
                        rsp_next.allow = 1'b1;
                        if (!is_tcp)
                        begin
                            we              = 1'b1;
                            wdata.seen_tick = tick_reg;
                            rsp_next.action = ACT_REFRESHED;
                        end
                        else if ((req_reg.tcp_flags & FLAG_RST) != 8'd0)
                        begin
                            we              = 1'b1;
                            wdata.active    = 1'b0;
                            rsp_next.action = ACT_RESET;
                        end
                        else
                        begin
                            case (rd_reg.conn_state)
                                ST_SYN_SENT:
                                begin
                                    if ((req_reg.tcp_flags & FLAG_SYN) != 8'd0
                                        && (req_reg.tcp_flags & FLAG_ACK) != 8'd0)
                                    begin
                                        we               = 1'b1;
                                        wdata.conn_state = ST_ESTABLISHED;
                                        wdata.seen_tick  = tick_reg;
                                        rsp_next.action  = ACT_TO_EST;
                                    end
                                    else
                                    begin
                                        rsp_next.allow  = 1'b0;
                                        rsp_next.action = ACT_REFUSED;
                                    end
                                end
                                ST_ESTABLISHED:
                                begin
                                    we              = 1'b1;
                                    wdata.seen_tick = tick_reg;
                                    if ((req_reg.tcp_flags & FLAG_FIN) != 8'd0)
                                    begin
                                        wdata.conn_state = ST_FIN_WAIT;
                                        rsp_next.action  = ACT_TO_FIN;
                                    end
                                    else
                                        rsp_next.action = ACT_REFRESHED;
                                end
                                ST_FIN_WAIT:
                                begin
                                    we              = 1'b1;
                                    wdata.seen_tick = tick_reg;
                                    rsp_next.action = ACT_REFRESHED;
                                end
                                default:
                                begin
                                    rsp_next.allow  = 1'b0;
                                    rsp_next.action = ACT_REFUSED;
                                end
                            endcase
                        end
                    end
                end
                if (state_next != S_DONE)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    prb_next = prb_reg + PRB_W'(1);
                    if (prb_reg == PRB_W'(PROBE_DEPTH - 1))
                    begin
                        if (!is_out)
                        begin
                            rsp_next.action = ACT_NO_MATCH;
                            state_next      = S_DONE;
                        end
                        else if (!have_free_next)
                        begin
                            rsp_next.action = ACT_FULL;
                            state_next      = S_DONE;
                        end
                        else
                            state_next = S_WRITE;
                    end
                end
            end
            S_WRITE:
            begin
                we                = 1'b1;
                waddr             = free_reg;
                wdata.active      = 1'b1;
                wdata.peer_ip     = rem_ip;
                wdata.peer_port   = rem_port;
                wdata.local_ip    = req_reg.src_ip;
                wdata.local_port  = req_reg.src_port;
                wdata.is_tcp      = is_tcp;
                wdata.seen_tick   = tick_reg;
                wdata.conn_state  = (is_tcp && (req_reg.tcp_flags & FLAG_SYN) != 8'd0
                                     && (req_reg.tcp_flags & FLAG_ACK) == 8'd0)
                                    ? ST_SYN_SENT : ST_ESTABLISHED;
                rsp_next.action   = ACT_CREATED;
                rsp_next.slot     = 10'(free_reg);
                state_next        = S_DONE;
            end
            S_CLEAN_RD:
                state_next = S_CLEAN_WT;
            S_CLEAN_WT:
                state_next = S_CLEAN_CK;
            S_CLEAN_CK:
            begin
                if (rd_reg.active && !live)
                begin
                    we           = 1'b1;
                    wdata.active = 1'b0;
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                    state_next = S_DONE;
                else
                    state_next = S_CLEAN_RD;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            idx_reg    <= '0;
            tick_reg   <= '0;
            to_est_reg <= 32'd300;
            to_fin_reg <= 32'd30;
            to_syn_reg <= 32'd60;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            tick_reg  <= tick_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TO_EST: to_est_reg <= cfg_data;
                    REG_TO_FIN: to_fin_reg <= cfg_data;
                    REG_TO_SYN: to_syn_reg <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        hash_reg      <= hash_next;
        mix_reg       <= mix_next;
        step_reg      <= step_next;
        prb_reg       <= prb_next;
        have_free_reg <= have_free_next;
        free_reg      <= free_next;
        rsp_reg       <= rsp_next;
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[idx_reg];
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);
    assign rsp  = rsp_reg;

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result held more than one cycle");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted start did not go busy");
    a_allow_act: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.allow) |-> (rsp.action != ACT_NO_MATCH && rsp.action != ACT_REFUSED))
        else $error("allow with refusing action");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Connection tracking table testbench
// Drives request beats into the connection tracking table core, predicts each
// response with a behavioral copy of the table and checks every response beat
// field by field. Timeouts are reprogrammed between phases while idle.
// ----------------------------------------------------------------------------
module testbench
    import ctt_pkg::*;
();

    localparam int CYCLE_LIMIT = 4000000;

    class conntrack_scoreboard;
        logic [31:0] to_est, to_fin, to_syn;
        logic [31:0] clock_ticks;
        bit          act_q[TABLE_ENTRIES];
        ctt_entry_t  tbl[TABLE_ENTRIES];
        ctt_out_t    pending[$];
        int          errors;

        function void reset_state();
            to_est = 32'd300;
            to_fin = 32'd30;
            to_syn = 32'd60;
            clock_ticks = '0;
            foreach (act_q[i]) act_q[i] = 1'b0;
            foreach (tbl[i]) tbl[i] = '0;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == REG_TO_EST) to_est = val;
            else if (idx == REG_TO_FIN) to_fin = val;
            else if (idx == REG_TO_SYN) to_syn = val;
        endfunction

        function logic [IDX_W-1:0] hash_slot(logic [31:0] ip, logic [15:0] port,
                                             logic [7:0] proto);
            logic [31:0] h;
            logic [7:0]  bytes[7];
            h = FNV_BASIS;
            bytes = '{ip[31:24], ip[23:16], ip[15:8], ip[7:0], port[15:8], port[7:0], proto};
            foreach (bytes[k]) h = (h ^ {24'd0, bytes[k]}) * FNV_PRIME;
            return h[IDX_W-1:0];
        endfunction

        function bit is_stale(int idx);
            logic [31:0] lim;
            case (tbl[idx].conn_state)
                ST_ESTABLISHED: lim = to_est;
                ST_FIN_WAIT:    lim = to_fin;
                default:        lim = to_syn;
            endcase
            return (clock_ticks - tbl[idx].seen_tick) > lim;
        endfunction

        function bit is_live(int idx);
            return act_q[idx] && !is_stale(idx);
        endfunction

        function ctt_out_t predict_outbound(ctt_in_t r);
            ctt_out_t o;
            logic [IDX_W-1:0] b, idx, free_idx;
            bit have_free, tcp;
            o = '0;
            b = hash_slot(r.dst_ip, r.dst_port, r.protocol);
            tcp = (r.protocol == PROTO_TCP);
            have_free = 1'b0;
            free_idx = '0;
            for (int i = 0; i < PROBE_DEPTH; i++) begin
                idx = b + IDX_W'(i);
                if (!is_live(idx)) begin
                    if (!have_free) begin
                        have_free = 1'b1;
                        free_idx = idx;
                    end
                    continue;
                end
                if (tbl[idx].peer_ip == r.dst_ip && tbl[idx].peer_port == r.dst_port &&
                    tbl[idx].local_ip == r.src_ip && tbl[idx].local_port == r.src_port &&
                    tbl[idx].is_tcp == tcp)
                begin
                    o.slot = idx;
                    if (tcp && (r.tcp_flags & FLAG_RST) != 0) begin
                        act_q[idx] = 1'b0;
                        o.action = ACT_RESET;
                    end else if (tcp && (r.tcp_flags & FLAG_FIN) != 0) begin
                        tbl[idx].conn_state = ST_FIN_WAIT;
                        tbl[idx].seen_tick = clock_ticks;
                        o.action = ACT_TO_FIN;
                    end else begin
                        tbl[idx].seen_tick = clock_ticks;
                        o.action = ACT_REFRESHED;
                    end
                    return o;
                end
            end
            if (!have_free) begin
                o.action = ACT_FULL;
                return o;
            end
            tbl[free_idx].peer_ip = r.dst_ip;
            tbl[free_idx].peer_port = r.dst_port;
            tbl[free_idx].local_ip = r.src_ip;
            tbl[free_idx].local_port = r.src_port;
            tbl[free_idx].is_tcp = tcp;
            tbl[free_idx].seen_tick = clock_ticks;
            tbl[free_idx].conn_state = (tcp && (r.tcp_flags & FLAG_SYN) != 0 &&
                                        (r.tcp_flags & FLAG_ACK) == 0)
                                       ? ST_SYN_SENT : ST_ESTABLISHED;
            act_q[free_idx] = 1'b1;
            o.action = ACT_CREATED;
            o.slot = free_idx;
            return o;
        endfunction

        function ctt_out_t predict_inbound(ctt_in_t r);
            ctt_out_t o;
            logic [IDX_W-1:0] b, idx;
            bit tcp;
            o = '0;
            b = hash_slot(r.src_ip, r.src_port, r.protocol);
            tcp = (r.protocol == PROTO_TCP);
            for (int i = 0; i < PROBE_DEPTH; i++) begin
                idx = b + IDX_W'(i);
                if (!is_live(idx)) continue;
                if (tbl[idx].peer_ip != r.src_ip || tbl[idx].peer_port != r.src_port ||
                    tbl[idx].is_tcp != tcp) continue;
                o.slot = idx;
                o.allow = 1'b1;
                if (!tcp) begin
                    tbl[idx].seen_tick = clock_ticks;
                    o.action = ACT_REFRESHED;
                end else if ((r.tcp_flags & FLAG_RST) != 0) begin
                    act_q[idx] = 1'b0;
                    o.action = ACT_RESET;
                end else if (tbl[idx].conn_state == ST_SYN_SENT) begin
                    if ((r.tcp_flags & FLAG_SYN) != 0 && (r.tcp_flags & FLAG_ACK) != 0) begin
                        tbl[idx].conn_state = ST_ESTABLISHED;
                        tbl[idx].seen_tick = clock_ticks;
                        o.action = ACT_TO_EST;
                    end else begin
                        o.allow = 1'b0;
                        o.action = ACT_REFUSED;
                    end
                end else if (tbl[idx].conn_state == ST_ESTABLISHED) begin
                    if ((r.tcp_flags & FLAG_FIN) != 0) begin
                        tbl[idx].conn_state = ST_FIN_WAIT;
                        o.action = ACT_TO_FIN;
                    end else begin
                        o.action = ACT_REFRESHED;
                    end
                    tbl[idx].seen_tick = clock_ticks;
                end else if (tbl[idx].conn_state == ST_FIN_WAIT) begin
                    tbl[idx].seen_tick = clock_ticks;
                    o.action = ACT_REFRESHED;
                end else begin
                    o.allow = 1'b0;
                    o.action = ACT_REFUSED;
                end
                return o;
            end
            o.action = ACT_NO_MATCH;
            return o;
        endfunction

        function void note_request(ctt_in_t r);
            ctt_out_t o;
            bit l4proto;
            o = '0;
            l4proto = (r.protocol == PROTO_TCP || r.protocol == PROTO_UDP);
            case (r.operation)
                OP_OUT:
                    if (r.ipv4_valid && r.l4_present && l4proto) o = predict_outbound(r);
                OP_IN:
                    if (r.ipv4_valid && r.protocol == PROTO_ICMP) o.allow = 1'b1;
                    else if (!r.ipv4_valid || !l4proto || !r.l4_present) o.action = ACT_REFUSED;
                    else o = predict_inbound(r);
                OP_TICK:
                    clock_ticks = clock_ticks + 32'd1;
                default:
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (act_q[i] && is_stale(i)) act_q[i] = 1'b0;
            endcase
            pending.push_back(o);
        endfunction

        function void check_response(ctt_out_t got);
            ctt_out_t want;
            if (pending.size() == 0) begin
                $error("unexpected response beat %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.allow !== want.allow) begin
                $error("allow: expected %0d actual %0d", want.allow, got.allow);
                errors++;
            end
            if (got.action !== want.action) begin
                $error("action: expected %0d actual %0d", want.action, got.action);
                errors++;
            end
            if (got.slot !== want.slot) begin
                $error("slot: expected %0d actual %0d", want.slot, got.slot);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    ctt_in_t     req = '0;
    logic        busy, done;
    ctt_out_t    rsp;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    conntrack_scoreboard sb;
    int          cycles = 0;
    int          idle_pct = 0;
    ctt_in_t     flows[$];

    connection_tracking_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .busy      (busy),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && done) sb.check_response(rsp);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // called at a falling edge; busy cannot rise before the next rising edge
    task automatic send_beat(ctt_in_t r);
        while (busy) @(negedge clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
        req <= r;
        start <= 1'b1;
        sb.note_request(r);
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_timeout(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    function automatic ctt_in_t rand_beat();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(ctt_in_t)-1:0];
    endfunction

    function automatic ctt_in_t make_pkt(logic [1:0] op, logic [7:0] proto,
                                         logic [7:0] flags);
        ctt_in_t r;
        r = '0;
        r.operation = op;
        r.ipv4_valid = 1'b1;
        r.l4_present = 1'b1;
        r.protocol = proto;
        r.src_ip = $urandom;
        r.dst_ip = $urandom;
        r.src_port = 16'($urandom);
        r.dst_port = 16'($urandom);
        r.tcp_flags = flags;
        return r;
    endfunction

    // outbound beat toward a remembered flow, or the matching inbound reply
    function automatic ctt_in_t flow_beat(ctt_in_t f, bit reply);
        ctt_in_t r;
        logic [7:0] fl;
        r = f;
        case ($urandom_range(7))
            0: fl = FLAG_SYN;
            1: fl = FLAG_SYN | FLAG_ACK;
            2: fl = FLAG_FIN | FLAG_ACK;
            3: fl = FLAG_RST;
            4: fl = 8'($urandom);
            default: fl = FLAG_ACK;
        endcase
        r.tcp_flags = fl;
        if (reply) begin
            r.operation = OP_IN;
            r.src_ip = f.dst_ip;
            r.src_port = f.dst_port;
            r.dst_ip = f.src_ip;
            r.dst_port = f.src_port;
        end
        return r;
    endfunction

    task automatic random_items(int count);
        ctt_in_t r, f;
        int k;
        for (int n = 0; n < count; n++) begin
            k = $urandom_range(99);
            if (k < 25 || flows.size() == 0) begin
                r = make_pkt(OP_OUT, ($urandom_range(1) != 0) ? PROTO_TCP : PROTO_UDP,
                             ($urandom_range(1) != 0) ? FLAG_SYN : FLAG_ACK);
                // a few flows share a remote so they probe the same slots
                if (flows.size() != 0 && $urandom_range(3) == 0) begin
                    f = flows[$urandom_range(flows.size() - 1)];
                    r.dst_ip = f.dst_ip;
                    r.dst_port = f.dst_port;
                    r.protocol = f.protocol;
                end
                if (flows.size() < 64) flows.push_back(r);
                else flows[$urandom_range(63)] = r;
            end else if (k < 70) begin
                f = flows[$urandom_range(flows.size() - 1)];
                r = flow_beat(f, $urandom_range(1) != 0);
            end else if (k < 82) begin
                r = rand_beat();
                r.operation = OP_TICK;
            end else if (k < 85) begin
                r = rand_beat();
                r.operation = OP_CLEAN;
            end else begin
                r = rand_beat();
                r.operation = ($urandom_range(1) != 0) ? OP_OUT : OP_IN;
                if ($urandom_range(1) != 0) r.protocol = PROTO_ICMP;
            end
            send_beat(r);
        end
    endtask

    initial begin
        ctt_in_t r, f;
        sb = new();
        sb.reset_state();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: handshake of one TCP flow, UDP, specials
        f = make_pkt(OP_OUT, PROTO_TCP, FLAG_SYN);
        f.src_ip = '1; f.dst_ip = '0; f.src_port = '1; f.dst_port = '0;
        send_beat(f);
        send_beat(f);
        r = f; r.tcp_flags = FLAG_SYN | FLAG_ACK;
        send_beat(flow_beat(r, 1'b1) );
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_ACK; send_beat(r);
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_SYN | FLAG_ACK; send_beat(r);
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_FIN; send_beat(r);
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_ACK; send_beat(r);
        r = f; r.tcp_flags = FLAG_FIN; send_beat(r);
        r = f; r.tcp_flags = FLAG_RST; send_beat(r);
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_RST; send_beat(r);
        r = f; r.tcp_flags = FLAG_ACK | FLAG_SYN; send_beat(r);
        r = flow_beat(f, 1'b1); r.tcp_flags = FLAG_RST; send_beat(r);
        f = make_pkt(OP_OUT, PROTO_UDP, 8'hFF);
        send_beat(f);
        send_beat(f);
        send_beat(flow_beat(f, 1'b1));
        // fill one probe window until full
        for (int i = 0; i < PROBE_DEPTH + 1; i++) begin
            r = f; r.src_port = 16'(i + 1); send_beat(r);
        end
        r = make_pkt(OP_OUT, PROTO_ICMP, 8'd0); send_beat(r);
        r = make_pkt(OP_OUT, PROTO_TCP, 8'd0); r.ipv4_valid = 1'b0; send_beat(r);
        r = make_pkt(OP_IN, PROTO_ICMP, 8'd0); send_beat(r);
        r = make_pkt(OP_IN, PROTO_ICMP, 8'd0); r.ipv4_valid = 1'b0; send_beat(r);
        r = make_pkt(OP_IN, PROTO_TCP, 8'd0); r.l4_present = 1'b0; send_beat(r);
        r = make_pkt(OP_IN, 8'd255, 8'd0); send_beat(r);
        r = make_pkt(OP_IN, PROTO_UDP, 8'd0); send_beat(r);
        r = make_pkt(OP_TICK, 8'd0, 8'd0); send_beat(r);
        r = make_pkt(OP_CLEAN, 8'd0, 8'd0); send_beat(r);
        drain();

        idle_pct = 24;
        set_timeout(REG_TO_EST, 32'd0);
        set_timeout(REG_TO_FIN, 32'd1);
        set_timeout(REG_TO_SYN, 32'd2);
        random_items(350);
        drain();

        idle_pct = 74;
        set_timeout(REG_TO_EST, 32'hFFFF_FFFF);
        set_timeout(REG_TO_FIN, 32'hFFFF_FFFF);
        set_timeout(REG_TO_SYN, 32'hFFFF_FFFF);
        random_items(350);
        drain();

        idle_pct = 0;
        set_timeout(REG_TO_EST, $urandom_range(40));
        set_timeout(REG_TO_FIN, $urandom_range(10));
        set_timeout(REG_TO_SYN, $urandom_range(20));
        random_items(350);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/ctt_pkg.sv
hdl/connection_tracking_table_core.sv
tb/sv/testbench.sv
